### hdl/ptls_pkg.sv
// Shared phase codes, reset constants and tick arithmetic helpers for the
// pedestrian traffic light sequencer. No dependencies.
package ptls_pkg;

  localparam int TICK_W  = 7;
  localparam int PHASE_W = 2;
  localparam int DIGIT_W = 3;

  localparam logic [PHASE_W-1:0] PH_STOP  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SLOW1 = 2'd1;
  localparam logic [PHASE_W-1:0] PH_GO    = 2'd2;
  localparam logic [PHASE_W-1:0] PH_SLOW2 = 2'd3;

  localparam logic [TICK_W-1:0] TICKS_RESET = 7'd100;
  localparam logic [TICK_W-1:0] DIGIT_TICKS = 7'd20;
  localparam logic [TICK_W-1:0] BLINK_TICKS = 7'd10;

  typedef logic [TICK_W-1:0]  tick_t;
  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  // Quotient of a tick count by twenty, found by comparing against each
  // multiple that a seven-bit count can reach.
  function automatic digit_t div_twenty(input tick_t t);
    digit_t q;
    q = '0;
    for (int k = 1; k <= 6; k++) begin
      if (t >= TICK_W'(k * 20)) begin
        q = DIGIT_W'(k);
      end
    end
    return q;
  endfunction

  // Effective phase length: a zero setting counts as one tick.
  function automatic tick_t eff_ticks(input tick_t t);
    return (t == '0) ? tick_t'(1) : t;
  endfunction

endpackage

### hdl/pedestrian_traffic_light_sequencer_top.sv
// Pedestrian traffic light sequencer: phase state, tick timer and the
// registered result stage. Depends on ptls_pkg.
//
// Usage: each transfer on the in_ channel is one 50 ms tick, with
// in_button_press high if the pedestrian button fell during it. For every
// tick exactly one result transfer leaves on the out_ channel with the lamp
// states, the phase that used the tick, the message select and the
// countdown digit with its strobe.
// The cfg_ channel writes the phase length in ticks; cfg_ready is always
// high. It should be written only while no tick is in flight.
// Output valid rises in the cycle after the input transfer. Throughput is
// one tick per cycle, set by the single result register: a new tick is
// taken whenever the result register is empty or is being read out in the
// same cycle.
// Reset puts the light in the stop phase with 100 ticks to go, walk lamp
// and yellow lamp off, no request pending, and a phase length of 100.
// When the receiver stalls with a result held, in_ready drops and the
// held result stays unchanged until it is taken.
module pedestrian_traffic_light_sequencer_top
  import ptls_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_phase_ticks,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_button_press,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_red_on,
  output logic       out_yellow_on,
  output logic       out_green_on,
  output logic       out_walk_on,
  output logic [1:0] out_phase_now,
  output logic       out_message_sel,
  output logic       out_digit_strobe,
  output logic [2:0] out_countdown_digit
);

  tick_t  phase_ticks_r;
  phase_t phase_r, phase_nxt;
  tick_t  ticks_r, ticks_nxt;
  logic   req_r, req_nxt;
  logic   walk_r, walk_nxt;
  logic   yellow_r, yellow_nxt;
  logic   msg_r, msg_nxt;
  logic   out_valid_r;

  logic   red_r, green_r, strobe_r, strobe_nxt;
  phase_t ph_out_r;
  digit_t digit_r, digit_nxt;

  logic   in_fire;
  logic   phase_end;
  tick_t  eff;
  tick_t  rem;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign eff       = eff_ticks(phase_ticks_r);

  always_comb begin
    phase_nxt  = phase_r;
    ticks_nxt  = ticks_r;
    walk_nxt   = walk_r;
    yellow_nxt = yellow_r;
    msg_nxt    = msg_r;
    req_nxt    = req_r || (in_button_press && !walk_r);

    // A request during go cuts green short, which ends the phase at once.
    phase_end = (ticks_r == '0) || ((phase_r == PH_GO) && req_nxt);
    if (phase_end) begin
      ticks_nxt = eff;
      case (phase_r)
        PH_STOP: begin
          msg_nxt = 1'b0;
          if (walk_r) begin
            walk_nxt  = 1'b0;
            phase_nxt = req_nxt ? PH_STOP : PH_GO;
          end else begin
            phase_nxt = PH_SLOW1;
          end
        end
        PH_SLOW1: begin
          yellow_nxt = 1'b0;
          phase_nxt  = req_nxt ? PH_STOP : PH_GO;
        end
        PH_GO: begin
          phase_nxt = PH_SLOW2;
        end
        default: begin
          yellow_nxt = 1'b0;
          phase_nxt  = PH_STOP;
        end
      endcase
    end

    if (phase_nxt == PH_STOP) begin
      if (req_nxt) begin
        req_nxt   = 1'b0;
        ticks_nxt = eff;
        walk_nxt  = 1'b1;
        msg_nxt   = 1'b1;
      end
    end

    digit_nxt  = div_twenty(ticks_nxt);
    rem        = ticks_nxt - TICK_W'(digit_nxt) * DIGIT_TICKS;
    strobe_nxt = (rem == '0);
    if ((phase_nxt == PH_SLOW1) || (phase_nxt == PH_SLOW2)) begin
      if ((rem == '0) || (rem == BLINK_TICKS)) begin
        yellow_nxt = !yellow_nxt;
      end
    end

    if (ticks_nxt != '0) begin
      ticks_nxt = ticks_nxt - tick_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= TICKS_RESET;
      phase_r       <= PH_STOP;
      ticks_r       <= TICKS_RESET;
      req_r         <= 1'b0;
      walk_r        <= 1'b0;
      yellow_r      <= 1'b0;
      msg_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        phase_ticks_r <= cfg_phase_ticks;
      end
      if (in_fire) begin
        phase_r  <= phase_nxt;
        ticks_r  <= ticks_nxt;
        req_r    <= req_nxt;
        walk_r   <= walk_nxt;
        yellow_r <= yellow_nxt;
        msg_r    <= msg_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      red_r    <= (phase_nxt == PH_STOP);
      green_r  <= (phase_nxt == PH_GO);
      ph_out_r <= phase_nxt;
      strobe_r <= strobe_nxt;
      digit_r  <= digit_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_red_on          = red_r;
  assign out_yellow_on       = yellow_r;
  assign out_green_on        = green_r;
  assign out_walk_on         = walk_r;
  assign out_phase_now       = ph_out_r;
  assign out_message_sel     = msg_r;
  assign out_digit_strobe    = strobe_r;
  assign out_countdown_digit = digit_r;

  a_walk_in_stop: assert property (@(posedge clk) disable iff (!rst_n)
    walk_r |-> (phase_r == PH_STOP))
    else $error("walk lamp lit outside the stop phase");

  a_msg_tracks_walk: assert property (@(posedge clk) disable iff (!rst_n)
    msg_r == walk_r)
    else $error("pedestrian message out of step with walk lamp");

  a_req_only_slow: assert property (@(posedge clk) disable iff (!rst_n)
    req_r |-> ((phase_r == PH_SLOW1) || (phase_r == PH_SLOW2)))
    else $error("walk request left pending outside a slow-down phase");

  a_yellow_only_slow: assert property (@(posedge clk) disable iff (!rst_n)
    yellow_r |-> ((phase_r == PH_SLOW1) || (phase_r == PH_SLOW2)))
    else $error("yellow lamp lit outside a slow-down phase");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted tick produced no result");

endmodule
